// ----- sv/fpd_pkg.sv -----
// fpd_pkg: shared types, constants and helper functions of the fuzzy PD wheel speed controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

	// field and datapath widths
	localparam int VEL_W   = 9;   // drive and target velocities
	localparam int TICK_W  = 11;  // decoded and doubled tick count
	localparam int ERR_W   = 11;  // speed error
	localparam int DERR_W  = 12;  // error difference
	localparam int MEMB_W  = 4;   // membership degree 0..10
	localparam int WSUM_W  = 13;  // weighted gain sum
	localparam int DEN_W   = 5;   // weight sum, divisor
	localparam int NUMP_W  = 24;  // proportional numerator
	localparam int NUMD_W  = 25;  // derivative numerator
	localparam int DIV_W   = 23;  // divider magnitude width
	localparam int FAULT_W = 25;  // accumulated correction
	localparam int SUM_W   = 26;  // velocity plus correction
	localparam int CNT_W   = 5;   // divider step counter

	localparam logic [MEMB_W-1:0] MEMB_SPAN = 4'd10;
	localparam logic signed [DERR_W-1:0] SPAN_POS = 12'sd10;
	localparam logic signed [DERR_W-1:0] SPAN_NEG = -12'sd10;
	localparam logic signed [SUM_W-1:0] LIMIT_POS = 26'sd254;
	localparam logic signed [SUM_W-1:0] LIMIT_NEG = -26'sd254;
	localparam logic [7:0] LIMIT_BYTE = 8'd254;
	localparam logic [2:0] PKT_LEN = 3'd5;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TEAM_ID,
		REG_BOT_ID,
		REG_KP_SMALL,
		REG_KP_MEDIUM,
		REG_KP_LARGE,
		REG_KD_SMALL,
		REG_KD_MEDIUM,
		REG_KD_LARGE
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] team_id;
		logic       bot_id;
		logic [7:0] kp_sml;
		logic [7:0] kp_mid;
		logic [7:0] kp_lrg;
		logic [7:0] kd_sml;
		logic [7:0] kd_mid;
		logic [7:0] kd_lrg;
	} cfg_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_FUZZ,
		ST_WMUL,
		ST_NMUL,
		ST_PSTART,
		ST_PDIV,
		ST_DSTART,
		ST_DDIV,
		ST_UPD
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic pkt_en;
		logic tick_en;
		logic err_en;
		logic fuzz_en;
		logic wmul_en;
		logic nmul_en;
		logic div_start;
		logic div_sel;   // 0 proportional term, 1 derivative term
		logic acc_en;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_busy;
	} status_t;

	typedef struct packed {
		logic [MEMB_W-1:0] neg;
		logic [MEMB_W-1:0] zero;
		logic [MEMB_W-1:0] pos;
	} memb_t;

	// triangular memberships of span ten
	function automatic memb_t fuzzify(input logic signed [DERR_W-1:0] x);
		memb_t m;
		logic [DERR_W-1:0] mag;
		m = '0;
		mag = -x;
		if (x > SPAN_POS) begin
			m.pos = MEMB_SPAN;
		end else if (x < SPAN_NEG) begin
			m.neg = MEMB_SPAN;
		end else if (x > 0) begin
			m.pos = x[MEMB_W-1:0];
			m.zero = MEMB_SPAN - x[MEMB_W-1:0];
		end else begin
			m.neg = mag[MEMB_W-1:0];
			m.zero = MEMB_SPAN - mag[MEMB_W-1:0];
		end
		return m;
	endfunction

	function automatic logic [MEMB_W-1:0] fmin(input logic [MEMB_W-1:0] a,
			input logic [MEMB_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [MEMB_W-1:0] fmax(input logic [MEMB_W-1:0] a,
			input logic [MEMB_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// command byte: 2b, or 2b-510 above 127, folded into nine bits
	function automatic logic signed [VEL_W-1:0] decode_cmd(input logic [7:0] b);
		logic [VEL_W-1:0] v;
		v = {b, 1'b0};
		if (b[7]) begin
			v = v + 9'd2;
		end
		return $signed(v);
	endfunction

endpackage

`default_nettype wire

// ----- sv/fpd_div.sv -----
// fpd_div: restoring divider, one quotient bit per cycle, unsigned magnitudes
// uses fpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpd_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [fpd_pkg::DIV_W-1:0] num,
	input  wire logic [fpd_pkg::DEN_W-1:0] den,
	output logic                           busy,
	output logic [fpd_pkg::DIV_W-1:0]      quo
);
	import fpd_pkg::*;

	logic [DIV_W-1:0] qn_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	// trial subtraction of the next bit
	always_comb begin
		trial = {rem_q, qn_q[DIV_W-1]};
		fits = (trial >= {1'b0, den_q});
		diff = trial - {1'b0, den_q};
	end

	// control: step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DIV_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift register holds dividend bits then quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			qn_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			qn_q <= {qn_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo = qn_q;

endmodule

`default_nettype wire

// ----- sv/fpd_ctrl.sv -----
// fpd_ctrl: sequencing state machine and output valid flag
// uses fpd_pkg; drives the datapath fpd_dp through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module fpd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             func,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output fpd_pkg::cmd_t         cmd,
	input  wire fpd_pkg::status_t status
);
	import fpd_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (func) begin
						cmd.tick_en = 1'b1;
						state_n = ST_ERR;
					end else begin
						cmd.pkt_en = 1'b1;
					end
				end
			end
			ST_ERR: begin
				cmd.err_en = 1'b1;
				state_n = ST_FUZZ;
			end
			ST_FUZZ: begin
				cmd.fuzz_en = 1'b1;
				state_n = ST_WMUL;
			end
			ST_WMUL: begin
				cmd.wmul_en = 1'b1;
				state_n = ST_NMUL;
			end
			ST_NMUL: begin
				cmd.nmul_en = 1'b1;
				state_n = ST_PSTART;
			end
			ST_PSTART: begin
				cmd.div_start = 1'b1;
				state_n = ST_PDIV;
			end
			ST_PDIV: begin
				if (!status.div_busy) begin
					cmd.acc_en = 1'b1;
					state_n = ST_DSTART;
				end
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b1;
				state_n = ST_DDIV;
			end
			ST_DDIV: begin
				cmd.div_sel = 1'b1;
				if (!status.div_busy) begin
					cmd.acc_en = 1'b1;
					state_n = ST_UPD;
				end
			end
			ST_UPD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- sv/fpd_dp.sv -----
// fpd_dp: packet decode, error, fuzzy weights, gain products, division and velocity update
// uses fpd_pkg and fpd_div; controlled by fpd_ctrl
`timescale 1ns / 1ps
`default_nettype none

module fpd_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire fpd_pkg::cfg_t             cfg,
	input  wire fpd_pkg::cmd_t             cmd,
	output fpd_pkg::status_t               status,
	input  wire logic                      wheel,
	input  wire logic [7:0]                data_byte,
	output logic                           wheel_out,
	output logic signed [fpd_pkg::VEL_W-1:0] drive_velocity,
	output logic [7:0]                     compare_a,
	output logic [7:0]                     compare_b
);
	import fpd_pkg::*;

	// packet position and per-wheel state
	logic [2:0]                pos_q;
	logic signed [VEL_W-1:0]   pend_q [2];
	logic signed [VEL_W-1:0]   tgt_q [2];
	logic signed [ERR_W-1:0]   prev_q [2];
	logic signed [VEL_W-1:0]   motor_q [2];

	// work registers of the current tick
	logic                      wheel_q;
	logic [7:0]                tick_q;
	logic signed [ERR_W-1:0]   e_q;
	logic signed [DERR_W-1:0]  de_q;
	logic [MEMB_W-1:0]         ps_q, pm_q, pl_q, ds_q, dm_q, dl_q;
	logic [WSUM_W-1:0]         psum_q, dsum_q;
	logic [DEN_W-1:0]          pden_q, dden_q;
	logic signed [NUMP_W-1:0]  nump_q;
	logic signed [NUMD_W-1:0]  numd_q;
	logic                      neg_q;
	logic signed [FAULT_W-1:0] fault_q;

	// result registers
	logic                      wheel_out_q;
	logic signed [VEL_W-1:0]   vel_q;
	logic [7:0]                cmp_a_q, cmp_b_q;

	// packet decode
	logic [2:0]                pair_pos;
	logic [2:0]                pos_n;
	logic signed [VEL_W-1:0]   cmd_val;
	logic signed [VEL_W-1:0]   pend0_n, pend1_n;

	always_comb begin
		pair_pos = {1'b0, cfg.bot_id, 1'b1};
		cmd_val = decode_cmd(data_byte);
		pend0_n = pend_q[0];
		pend1_n = pend_q[1];
		pos_n = pos_q;
		if (pos_q == 3'd0 && data_byte == cfg.team_id) begin
			pos_n = 3'd1;
		end else if (pos_q == pair_pos) begin
			pend0_n = cmd_val;
			pos_n = pos_q + 3'd1;
		end else if (pos_q == pair_pos + 3'd1) begin
			pend1_n = cmd_val;
			pos_n = pos_q + 3'd1;
		end else if (pos_q != 3'd0) begin
			pos_n = pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pend_q[0] <= '0;
			pend_q[1] <= '0;
			tgt_q[0] <= '0;
			tgt_q[1] <= '0;
		end else if (cmd.pkt_en) begin
			pend_q[0] <= pend0_n;
			pend_q[1] <= pend1_n;
			if (pos_n >= PKT_LEN) begin
				tgt_q[0] <= pend0_n;
				tgt_q[1] <= pend1_n;
				pos_q <= '0;
			end else begin
				pos_q <= pos_n;
			end
		end
	end

	// tick decode and speed error
	logic signed [TICK_W-1:0] tick2;
	logic signed [ERR_W-1:0]  e_n;
	logic signed [DERR_W-1:0] de_n;

	always_comb begin
		tick2 = $signed({2'b00, tick_q, 1'b0});
		if (tick_q > 8'd128) begin
			tick2 = tick2 - 11'sd510;
		end
		e_n = ERR_W'(tgt_q[wheel_q]) - tick2;
		de_n = DERR_W'(e_n) - DERR_W'(prev_q[wheel_q]);
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_en) begin
			wheel_q <= wheel;
			tick_q <= data_byte;
		end
		if (cmd.err_en) begin
			e_q <= e_n;
			de_q <= de_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q[0] <= '0;
			prev_q[1] <= '0;
		end else if (cmd.err_en) begin
			prev_q[wheel_q] <= e_n;
		end
	end

	// fuzzy rule table, min over pairs and max per output set
	memb_t me, md;
	logic [MEMB_W-1:0] f00, f01, f02, f10, f11, f12, f20, f21, f22;

	always_comb begin
		me = fuzzify(DERR_W'(e_q));
		md = fuzzify(de_q);
		f00 = fmin(md.neg,  me.neg);
		f01 = fmin(md.zero, me.neg);
		f02 = fmin(md.pos,  me.neg);
		f10 = fmin(md.neg,  me.zero);
		f11 = fmin(md.zero, me.zero);
		f12 = fmin(md.pos,  me.zero);
		f20 = fmin(md.neg,  me.pos);
		f21 = fmin(md.zero, me.pos);
		f22 = fmin(md.pos,  me.pos);
	end

	always_ff @(posedge clk) begin
		if (cmd.fuzz_en) begin
			ps_q <= f11;
			pm_q <= fmax(fmax(fmax(f10, f01), fmax(f21, f12)), fmax(f00, f22));
			pl_q <= fmax(f02, f20);
			ds_q <= fmax(fmax(f02, f20), f11);
			dm_q <= fmax(fmax(f00, f01), fmax(f21, f22));
			dl_q <= fmax(f10, f12);
		end
	end

	// weighted gain sums and weight sums
	always_ff @(posedge clk) begin
		if (cmd.wmul_en) begin
			psum_q <= WSUM_W'(ps_q) * WSUM_W'(cfg.kp_sml) + WSUM_W'(pm_q) * WSUM_W'(cfg.kp_mid)
				+ WSUM_W'(pl_q) * WSUM_W'(cfg.kp_lrg);
			dsum_q <= WSUM_W'(ds_q) * WSUM_W'(cfg.kd_sml) + WSUM_W'(dm_q) * WSUM_W'(cfg.kd_mid)
				+ WSUM_W'(dl_q) * WSUM_W'(cfg.kd_lrg);
			pden_q <= DEN_W'(ps_q) + DEN_W'(pm_q) + DEN_W'(pl_q);
			dden_q <= DEN_W'(ds_q) + DEN_W'(dm_q) + DEN_W'(dl_q);
		end
	end

	// numerators: error and error difference times weighted gain sums
	always_ff @(posedge clk) begin
		if (cmd.nmul_en) begin
			nump_q <= NUMP_W'(e_q) * $signed({1'b0, psum_q});
			numd_q <= NUMD_W'(de_q) * $signed({1'b0, dsum_q});
		end
	end

	// divider operand select, magnitude in and sign kept aside
	logic               sel_neg;
	logic [NUMD_W-1:0]  sel_num;
	logic [NUMD_W-1:0]  sel_mag;
	logic [DEN_W-1:0]   sel_den;
	logic               div_busy;
	logic [DIV_W-1:0]   div_quo;

	always_comb begin
		sel_num = cmd.div_sel ? numd_q : NUMD_W'(nump_q);
		sel_den = cmd.div_sel ? dden_q : pden_q;
		sel_neg = sel_num[NUMD_W-1];
		sel_mag = sel_neg ? -sel_num : sel_num;
	end

	fpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (sel_mag[DIV_W-1:0]),
		.den    (sel_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign status.div_busy = div_busy;

	// accumulate quotients truncated toward zero
	logic signed [FAULT_W-1:0] quo_s;

	assign quo_s = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= sel_neg;
		end
		if (cmd.err_en) begin
			fault_q <= '0;
		end else if (cmd.acc_en) begin
			fault_q <= fault_q + quo_s;
		end
	end

	// velocity update and clamp
	logic signed [SUM_W-1:0] vsum;
	logic signed [VEL_W-1:0] v_n;
	logic [7:0]              cmp_a_n, cmp_b_n;

	always_comb begin
		vsum = SUM_W'(motor_q[wheel_q]) + SUM_W'(fault_q);
		if (vsum < LIMIT_NEG) begin
			v_n = LIMIT_NEG[VEL_W-1:0];
		end else if (vsum > LIMIT_POS) begin
			v_n = LIMIT_POS[VEL_W-1:0];
		end else begin
			v_n = vsum[VEL_W-1:0];
		end
		if (v_n < 0) begin
			cmp_a_n = LIMIT_BYTE + v_n[7:0];
			cmp_b_n = LIMIT_BYTE;
		end else begin
			cmp_a_n = LIMIT_BYTE;
			cmp_b_n = LIMIT_BYTE - v_n[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_q[0] <= '0;
			motor_q[1] <= '0;
		end else if (cmd.out_load) begin
			motor_q[wheel_q] <= v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			wheel_out_q <= wheel_q;
			vel_q <= v_n;
			cmp_a_q <= cmp_a_n;
			cmp_b_q <= cmp_b_n;
		end
	end

	assign wheel_out = wheel_out_q;
	assign drive_velocity = vel_q;
	assign compare_a = cmp_a_q;
	assign compare_b = cmp_b_q;

endmodule

`default_nettype wire

// ----- sv/fuzzy_pd_wheel_speed_controller.sv -----
// fuzzy_pd_wheel_speed_controller: top level, configuration registers and block wiring
// uses fpd_pkg, fpd_ctrl, fpd_dp (with fpd_div)
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  func, wheel, data_byte
//   out      output     out_valid/out_stall  wheel_out, drive_velocity, compare_a, compare_b
//   cfg      input      cfg_wen              cfg_idx, cfg_wdata
//
// a command byte gives no result
// an encoder tick byte holds the input until its result is registered: four setup
// steps, two divider passes (start, 23 steps of the shared bit-serial divider,
// collect), then one update
// a new request is taken only when the sequencer is idle; the update step waits only
// while an earlier result is still held under out_stall
// asynchronous active-low reset clears packet, target, error and velocity state
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_pd_wheel_speed_controller (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        func,
	input  wire logic                        wheel,
	input  wire logic [7:0]                  data_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             wheel_out,
	output logic signed [fpd_pkg::VEL_W-1:0] drive_velocity,
	output logic [7:0]                       compare_a,
	output logic [7:0]                       compare_b,
	input  wire logic                        cfg_wen,
	input  wire logic [2:0]                  cfg_idx,
	input  wire logic [7:0]                  cfg_wdata
);
	import fpd_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{team_id: 8'd127, bot_id: 1'b1, default: '0};
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TEAM_ID:   cfg_q.team_id <= cfg_wdata;
				REG_BOT_ID:    cfg_q.bot_id <= cfg_wdata[0];
				REG_KP_SMALL:  cfg_q.kp_sml <= cfg_wdata;
				REG_KP_MEDIUM: cfg_q.kp_mid <= cfg_wdata;
				REG_KP_LARGE:  cfg_q.kp_lrg <= cfg_wdata;
				REG_KD_SMALL:  cfg_q.kd_sml <= cfg_wdata;
				REG_KD_MEDIUM: cfg_q.kd_mid <= cfg_wdata;
				REG_KD_LARGE:  cfg_q.kd_lrg <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	fpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath
	fpd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.status         (status),
		.wheel          (wheel),
		.data_byte      (data_byte),
		.wheel_out      (wheel_out),
		.drive_velocity (drive_velocity),
		.compare_a      (compare_a),
		.compare_b      (compare_b)
	);

endmodule

`default_nettype wire

// ----- tb/sv/fpd_speed_checker.sv -----
// fpd_speed_checker: watches the request, result and register ports of the speed controller,
// predicts each drive result and compares it field by field; uses fpd_pkg
`timescale 1ns / 1ps

module fpd_speed_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic                        func,
	input  wire logic                        wheel,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic                        wheel_out,
	input  wire logic signed [fpd_pkg::VEL_W-1:0] drive_velocity,
	input  wire logic [7:0]                  compare_a,
	input  wire logic [7:0]                  compare_b,
	input  wire logic                        cfg_wen,
	input  wire logic [2:0]                  cfg_idx,
	input  wire logic [7:0]                  cfg_wdata,
	output int                               mismatches,
	output int                               drives_waiting,
	output int                               drives_seen
);
	import fpd_pkg::*;

	localparam int SPAN = 10;
	localparam int LIMIT = 254;

	typedef struct {
		logic                    wheel;
		logic signed [VEL_W-1:0] velocity;
		logic [7:0]              cmp_a;
		logic [7:0]              cmp_b;
	} drive_t;

	drive_t drive_queue[$];

	// shadow registers and controller state
	logic [7:0] team_id_q;
	logic       bot_id_q;
	int         gain[6];
	int         pkt_pos;
	int         pend_vel[2], tgt_vel[2], prev_err[2], motor_vel[2];

	function automatic void membership(input int x, output int n, output int z, output int p);
		n = 0; z = 0; p = 0;
		if (x > SPAN) p = SPAN;
		else if (x < -SPAN) n = SPAN;
		else if (x > 0) begin
			p = x;
			z = SPAN - x;
		end else begin
			n = -x;
			z = SPAN + x;
		end
	endfunction

	function automatic int imin(input int a, input int b);
		return a < b ? a : b;
	endfunction

	function automatic int imax(input int a, input int b);
		return a > b ? a : b;
	endfunction

	function automatic int cmd_speed(input logic [7:0] b);
		return b > 127 ? -2 * (255 - int'(b)) : 2 * int'(b);
	endfunction

	// one encoder tick: fuzzy weighted PD correction added to the wheel velocity
	function automatic drive_t tick_drive(input logic w, input logic [7:0] b);
		drive_t d;
		int t, e, de, v, corr;
		int me[3], md[3], f[3][3];
		int ps, pm, pl, ds, dm, dl;
		t = int'(b);
		if (t > 128) t = t - 255;
		t = 2 * t;
		e = tgt_vel[w] - t;
		de = e - prev_err[w];
		prev_err[w] = e;
		membership(e, me[0], me[1], me[2]);
		membership(de, md[0], md[1], md[2]);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				f[r][c] = imin(md[c], me[r]);
		ps = f[1][1];
		pm = imax(imax(imax(f[1][0], f[0][1]), imax(f[2][1], f[1][2])),
			imax(f[0][0], f[2][2]));
		pl = imax(f[0][2], f[2][0]);
		ds = imax(imax(f[0][2], f[2][0]), f[1][1]);
		dm = imax(imax(f[0][0], f[0][1]), imax(f[2][1], f[2][2]));
		dl = imax(f[1][0], f[1][2]);
		corr = 0;
		if (ps + pm + pl != 0 && ds + dm + dl != 0) begin
			corr = (e * (ps * gain[0] + pm * gain[1] + pl * gain[2])) / (ps + pm + pl);
			corr += (de * (ds * gain[3] + dm * gain[4] + dl * gain[5])) / (ds + dm + dl);
		end
		v = motor_vel[w] + corr;
		if (v < -LIMIT) v = -LIMIT;
		if (v > LIMIT) v = LIMIT;
		motor_vel[w] = v;
		d.wheel = w;
		d.velocity = VEL_W'(v);
		d.cmp_a = 8'(v < 0 ? LIMIT + v : LIMIT);
		d.cmp_b = 8'(v < 0 ? LIMIT : LIMIT - v);
		return d;
	endfunction

	// command packet assembly
	function automatic void packet_byte(input logic [7:0] b);
		if (pkt_pos == 0 && b == team_id_q) pkt_pos = 1;
		else if (pkt_pos == 2 * bot_id_q + 1) begin
			pend_vel[0] = cmd_speed(b);
			pkt_pos++;
		end else if (pkt_pos == 2 * bot_id_q + 2) begin
			pend_vel[1] = cmd_speed(b);
			pkt_pos++;
		end else if (pkt_pos != 0) pkt_pos++;
		if (pkt_pos >= 5) begin
			tgt_vel[0] = pend_vel[0];
			tgt_vel[1] = pend_vel[1];
			pkt_pos = 0;
		end
	endfunction

	// prediction on accepted requests, comparison on accepted results
	always @(posedge clk or negedge arst_n) begin
		drive_t exp_d;
		if (!arst_n) begin
			team_id_q <= 8'd127;
			bot_id_q <= 1'b1;
			for (int k = 0; k < 6; k++) gain[k] = 0;
			pkt_pos = 0;
			for (int k = 0; k < 2; k++) begin
				pend_vel[k] = 0; tgt_vel[k] = 0; prev_err[k] = 0; motor_vel[k] = 0;
			end
			drive_queue.delete();
			mismatches <= 0;
			drives_seen <= 0;
			drives_waiting <= 0;
		end else begin
			if (cfg_wen) begin
				case (reg_idx_t'(cfg_idx))
					REG_TEAM_ID: team_id_q <= cfg_wdata;
					REG_BOT_ID:  bot_id_q <= cfg_wdata[0];
					default:     gain[int'(cfg_idx) - int'(REG_KP_SMALL)] = int'(cfg_wdata);
				endcase
			end
			if (in_valid && !in_stall) begin
				if (func) drive_queue.push_back(tick_drive(wheel, data_byte));
				else packet_byte(data_byte);
			end
			if (out_valid && !out_stall) begin
				drives_seen <= drives_seen + 1;
				if (drive_queue.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected drive result: wheel %0d velocity %0d",
							wheel_out, drive_velocity);
				end else begin
					exp_d = drive_queue.pop_front();
					if (exp_d.wheel !== wheel_out || exp_d.velocity !== drive_velocity ||
							exp_d.cmp_a !== compare_a || exp_d.cmp_b !== compare_b) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("drive mismatch: expected w%0d v%0d a%0d b%0d, got w%0d v%0d a%0d b%0d",
								exp_d.wheel, exp_d.velocity, exp_d.cmp_a, exp_d.cmp_b,
								wheel_out, drive_velocity, compare_a, compare_b);
					end
				end
			end
			drives_waiting <= drive_queue.size();
		end
	end

endmodule

// ----- tb/sv/tb_fuzzy_pd_wheel_speed_controller.sv -----
// tb_fuzzy_pd_wheel_speed_controller: clock, reset, packet and tick stimulus, register phases
// uses fpd_pkg, fuzzy_pd_wheel_speed_controller and fpd_speed_checker
`timescale 1ns / 1ps

module tb_fuzzy_pd_wheel_speed_controller;
	import fpd_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE = 100;

	logic clk, arst_n;
	logic in_valid, in_stall, func, wheel;
	logic [7:0] data_byte;
	logic out_valid, out_stall, wheel_out;
	logic signed [VEL_W-1:0] drive_velocity;
	logic [7:0] compare_a, compare_b;
	logic cfg_wen;
	logic [2:0] cfg_idx;
	logic [7:0] cfg_wdata;
	int mismatches, drives_waiting, drives_seen;
	int cycles;
	int requests_sent;
	logic [7:0] team_cur;

	fuzzy_pd_wheel_speed_controller dut (.*);

	fpd_speed_checker u_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver stalls, with one long hold-off so the block backs up
	initial begin
		int gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		repeat (3000) begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 3) == 0);
		end
		@(posedge clk);
		out_stall <= 1'b1;
		repeat (600) @(posedge clk);
		forever begin
			@(posedge clk);
			out_stall <= 1'b0;
			if ($urandom_range(0, 9) < 3) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end else if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end
		end
	end

	// one request; gap cycles of idling first
	task automatic send_request(input logic f, input logic w, input logic [7:0] b);
		int gap;
		gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90) :
			(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		wheel <= w;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic send_packet(input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4);
		send_request(1'b0, 1'($urandom_range(0, 1)), team_cur);
		send_request(1'b0, 1'($urandom_range(0, 1)), b1);
		send_request(1'b0, 1'($urandom_range(0, 1)), b2);
		send_request(1'b0, 1'($urandom_range(0, 1)), b3);
		send_request(1'b0, 1'($urandom_range(0, 1)), b4);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_TEAM_ID) team_cur = val;
	endtask

	// let the block drain before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (drives_waiting == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_gains(input logic [7:0] ps, input logic [7:0] pm, input logic [7:0] pl,
			input logic [7:0] ds, input logic [7:0] dm, input logic [7:0] dl);
		write_reg(REG_KP_SMALL, ps);
		write_reg(REG_KP_MEDIUM, pm);
		write_reg(REG_KP_LARGE, pl);
		write_reg(REG_KD_SMALL, ds);
		write_reg(REG_KD_MEDIUM, dm);
		write_reg(REG_KD_LARGE, dl);
	endtask

	// mostly ticks and well-formed packets, some stray and broken bytes
	task automatic random_traffic(input int count);
		int start, kind;
		start = requests_sent;
		while (requests_sent - start < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) send_request(1'b1, 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)));
			else if (kind < 85) send_packet(8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
			else if (kind < 92) begin
				send_request(1'b0, 1'b0, team_cur);
				send_request(1'b0, 1'b1, 8'($urandom_range(0, 255)));
			end else send_request(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		end
	endtask

	// stimulus and verdict
	initial begin
		in_valid = 1'b0;
		func = 1'b0;
		wheel = 1'b0;
		data_byte = 8'd0;
		cfg_wen = 1'b0;
		cfg_idx = REG_TEAM_ID;
		cfg_wdata = 8'd0;
		requests_sent = 0;
		team_cur = 8'd127;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, then mid gains
		send_packet(8'd0, 8'd127, 8'd128, 8'd255);
		send_request(1'b1, 1'b0, 8'd0);
		send_request(1'b1, 1'b1, 8'd255);
		drain();
		write_reg(REG_TEAM_ID, 8'hA5);
		write_reg(REG_BOT_ID, 8'hFE);
		set_gains(8'd40, 8'd80, 8'd120, 8'd10, 8'd30, 8'd60);
		cfg_wen <= 1'b0;
		send_request(1'b0, 1'b0, 8'd3);
		send_packet(8'd127, 8'd128, 8'd5, 8'd250);
		send_request(1'b1, 1'b0, 8'd128);
		send_request(1'b1, 1'b0, 8'd129);
		send_request(1'b1, 1'b1, 8'd127);
		send_request(1'b1, 1'b1, 8'd4);
		send_request(1'b1, 1'b0, 8'd250);
		send_packet(8'd255, 8'd0, 8'd1, 8'd2);
		send_request(1'b1, 1'b0, 8'd255);
		send_request(1'b1, 1'b1, 8'd0);
		random_traffic(150);

		// extremes: team byte zero, bot one, full gains
		drain();
		write_reg(REG_TEAM_ID, 8'h00);
		write_reg(REG_BOT_ID, 8'h01);
		set_gains(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		cfg_wen <= 1'b0;
		random_traffic(170);

		// team byte 255, zero gains
		drain();
		write_reg(REG_TEAM_ID, 8'hFF);
		write_reg(REG_BOT_ID, 8'h00);
		set_gains(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		cfg_wen <= 1'b0;
		random_traffic(120);

		// random setting
		drain();
		write_reg(REG_TEAM_ID, 8'($urandom_range(0, 255)));
		write_reg(REG_BOT_ID, 8'($urandom_range(0, 255)));
		set_gains(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		cfg_wen <= 1'b0;
		random_traffic(200);

		drain();
		$display("run covered %0d requests and %0d drive results over five register settings",
			requests_sent, drives_seen);
		$display("mismatches counted: %0d", mismatches);
		if (mismatches == 0 && drives_waiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
sv/fpd_pkg.sv
sv/fpd_div.sv
sv/fpd_ctrl.sv
sv/fpd_dp.sv
sv/fuzzy_pd_wheel_speed_controller.sv
tb/sv/fpd_speed_checker.sv
tb/sv/tb_fuzzy_pd_wheel_speed_controller.sv
